### rtl/core/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types and constants of the probe sequence tracker: table entry
// record, controller command and status bundles, codes and counter helper.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

	localparam logic [1:0] MODE_OBSERVE = 2'd0;
	localparam logic [1:0] MODE_SCAN    = 2'd1;
	localparam logic [1:0] MODE_FINAL   = 2'd2;

	localparam logic REG_RETAIN = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	localparam logic [11:0] DEFAULT_WINDOW = 12'd32;
	localparam logic [11:0] LONG_SEQ_LIMIT = 12'd2047;
	localparam logic [15:0] CNT_MAX        = 16'hFFFF;

	typedef struct packed {
		logic [47:0] address;
		logic [11:0] start_seq;
		logic [11:0] end_seq;
		logic [11:0] max_seq;
		logic [15:0] first_scan;
		logic [15:0] last_scan;
		logic [15:0] hits;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic cnt_total;
		logic scan_begin;
		logic lk_hit;
		logic take_new;
		logic ev_init;
		logic ev_step;
		logic ev_done;
		logic wr;
		logic f_clear;
		logic f_count;
		logic f_i_latch;
		logic f_link;
		logic f_apparent;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       detail;
		logic       full;
		logic       addr_hit;
		logic       older;
		logic       link_ok;
	} sts_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

`default_nettype wire

### rtl/core/psq_dp.sv
// ----------------------------------------------------------------------------
// psq_dp
// Datapath: entry memory, link marks, configuration, scan index, aggregate
// counters and output registers. Acts on commands from psq_ctrl.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_dp import psq_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int IW          = $clog2(TABLE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic          cfg_index,
	input  wire logic [11:0]   cfg_data,
	input  wire logic [1:0]    mode,
	input  wire logic [47:0]   source_address,
	input  wire logic [15:0]   sequence_number,
	input  wire cmd_t          cmd,
	input  wire logic [IW-1:0] idx,
	output sts_t               sts,
	output logic [IW:0]        fill,
	output logic [15:0]        total_probes,
	output logic [15:0]        dropped_entries,
	output logic [6:0]         distinct_addresses,
	output logic [6:0]         linked_count,
	output logic [6:0]         short_sequence_count,
	output logic [6:0]         long_sequence_count,
	output logic [6:0]         apparent_count
);

	localparam logic [IW:0] DEPTH_W = (IW+1)'(TABLE_DEPTH);

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;
	entry_t wdata;

	logic [1:0]    mode_q;
	logic [47:0]   addr_q;
	logic [11:0]   seq_q;
	logic          retain_q;
	logic [11:0]   window_q;
	logic [IW:0]   fill_q;
	logic [15:0]   scan_q;
	logic [15:0]   total_q, dropped_q, distinct_q, link_cnt_q, short_q, long_q, apparent_q;
	logic [TABLE_DEPTH-1:0] linked_q;
	logic [IW-1:0] slot_q;
	logic          fresh_q;
	logic [15:0]   oldest_q;
	logic [15:0]   ilast_scan_q;
	logic [11:0]   ilast_seq_q;
	logic [16:0]   scan_diff;
	logic [11:0]   seq_delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retain_q   <= 1'b0;
			window_q   <= DEFAULT_WINDOW;
			fill_q     <= '0;
			scan_q     <= '0;
			total_q    <= '0;
			dropped_q  <= '0;
			distinct_q <= '0;
			link_cnt_q <= '0;
			short_q    <= '0;
			long_q     <= '0;
			apparent_q <= '0;
			linked_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_RETAIN: retain_q <= cfg_data[0];
					REG_WINDOW: window_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.cnt_total) total_q <= sat_inc(total_q);
			if (cmd.scan_begin) begin
				scan_q   <= scan_q + 16'd1;
				linked_q <= '0;
			end
			if (cmd.take_new) fill_q <= fill_q + (IW+1)'(1);
			if (cmd.ev_done) dropped_q <= sat_inc(dropped_q);
			if (cmd.wr && fresh_q) linked_q[slot_q] <= 1'b0;
			if (cmd.f_clear) begin
				distinct_q <= '0;
				link_cnt_q <= '0;
				short_q    <= '0;
				long_q     <= '0;
			end
			if (cmd.f_count) begin
				distinct_q <= sat_inc(distinct_q);
				if (rdata_q.max_seq > LONG_SEQ_LIMIT) long_q <= sat_inc(long_q);
				else short_q <= sat_inc(short_q);
			end
			if (cmd.f_link) begin
				linked_q[idx] <= 1'b1;
				link_cnt_q    <= sat_inc(link_cnt_q);
			end
			if (cmd.f_apparent) begin
				apparent_q <= (distinct_q > link_cnt_q) ? distinct_q - link_cnt_q : 16'd0;
			end
		end
	end

	// new or evicted slot starts over; a hit keeps its first values
	always_comb begin
		wdata = rdata_q;
		if (fresh_q) begin
			wdata.address    = addr_q;
			wdata.start_seq  = seq_q;
			wdata.max_seq    = seq_q;
			wdata.first_scan = scan_q;
			wdata.hits       = 16'd1;
		end else begin
			if (seq_q > rdata_q.max_seq) wdata.max_seq = seq_q;
			wdata.hits = sat_inc(rdata_q.hits);
		end
		wdata.end_seq   = seq_q;
		wdata.last_scan = scan_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) mem[slot_q] <= wdata;
		if (cmd.rd_en) rdata_q <= mem[idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			addr_q <= source_address;
			seq_q  <= sequence_number[11:0];
		end
		if (cmd.lk_hit) begin
			slot_q  <= idx;
			fresh_q <= 1'b0;
		end
		if (cmd.take_new) begin
			slot_q  <= fill_q[IW-1:0];
			fresh_q <= 1'b1;
		end
		if (cmd.ev_init || (cmd.ev_step && sts.older)) begin
			oldest_q <= rdata_q.last_scan;
			slot_q   <= idx;
		end
		if (cmd.ev_done) fresh_q <= 1'b1;
		if (cmd.f_i_latch) begin
			ilast_scan_q <= rdata_q.last_scan;
			ilast_seq_q  <= rdata_q.end_seq;
		end
		if (cmd.out_load) begin
			total_probes         <= total_q;
			dropped_entries      <= dropped_q;
			distinct_addresses   <= distinct_q[6:0];
			linked_count         <= link_cnt_q[6:0];
			short_sequence_count <= short_q[6:0];
			long_sequence_count  <= long_q[6:0];
			apparent_count       <= apparent_q[6:0];
		end
	end

	assign scan_diff = {1'b0, ilast_scan_q} - {1'b0, rdata_q.first_scan};
	assign seq_delta = rdata_q.start_seq - ilast_seq_q;

	always_comb begin
		sts.mode     = mode_q;
		sts.detail   = retain_q;
		sts.full     = (fill_q == DEPTH_W);
		sts.addr_hit = (rdata_q.address == addr_q);
		sts.older    = (rdata_q.last_scan < oldest_q);
		// target not yet linked, scans adjacent and sequence moves forward within the window
		sts.link_ok  = !linked_q[idx]
			&& (scan_diff == 17'd0 || scan_diff == 17'd1 || scan_diff == 17'h1FFFF)
			&& (seq_delta != 12'd0) && (seq_delta <= window_q);
	end

	assign fill = fill_q;

endmodule

`default_nettype wire

### rtl/core/psq_ctrl.sv
// ----------------------------------------------------------------------------
// psq_ctrl
// Controller: sequences lookup, eviction search, entry update and the
// finalize passes over the table, and runs both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_ctrl import psq_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int IW          = $clog2(TABLE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire sts_t          sts,
	input  wire logic [IW:0]   fill,
	output cmd_t               cmd,
	output logic [IW-1:0]      idx
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_LK_RD   = 4'd2;
	localparam logic [3:0] S_LK_EV   = 4'd3;
	localparam logic [3:0] S_EV_RD   = 4'd4;
	localparam logic [3:0] S_EV_EV   = 4'd5;
	localparam logic [3:0] S_UPD     = 4'd6;
	localparam logic [3:0] S_F1_RD   = 4'd7;
	localparam logic [3:0] S_F1_EV   = 4'd8;
	localparam logic [3:0] S_F2I_RD  = 4'd9;
	localparam logic [3:0] S_F2I_EV  = 4'd10;
	localparam logic [3:0] S_F2J_CHK = 4'd11;
	localparam logic [3:0] S_F2J_EV  = 4'd12;
	localparam logic [3:0] S_F2_NEXT = 4'd13;
	localparam logic [3:0] S_F_APP   = 4'd14;
	localparam logic [3:0] S_DONE    = 4'd15;

	localparam logic [IW:0] LAST_IDX = (IW+1)'(TABLE_DEPTH - 1);

	logic [3:0]    state_q, state_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d;
	logic          out_valid_q;
	logic          i_last, j_last;

	assign i_last = (((IW+1)'(i_q) + (IW+1)'(1)) == fill);
	assign j_last = (((IW+1)'(j_q) + (IW+1)'(1)) == fill);

	always_comb begin
		cmd     = '0;
		idx     = i_q;
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.mode)
					MODE_OBSERVE: begin
						cmd.cnt_total = 1'b1;
						i_d = '0;
						if (!sts.detail) begin
							state_d = S_DONE;
						end else if (fill == '0) begin
							cmd.take_new = 1'b1;
							state_d = S_UPD;
						end else begin
							state_d = S_LK_RD;
						end
					end
					MODE_SCAN: begin
						cmd.scan_begin = 1'b1;
						state_d = S_DONE;
					end
					MODE_FINAL: begin
						cmd.f_clear = 1'b1;
						i_d = '0;
						state_d = (fill == '0) ? S_F_APP : S_F1_RD;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_LK_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_LK_EV;
			end
			S_LK_EV: begin
				if (sts.addr_hit) begin
					cmd.lk_hit = 1'b1;
					state_d = S_UPD;
				end else if (i_last) begin
					if (sts.full) begin
						i_d = '0;
						state_d = S_EV_RD;
					end else begin
						cmd.take_new = 1'b1;
						state_d = S_UPD;
					end
				end else begin
					i_d = i_q + IW'(1);
					state_d = S_LK_RD;
				end
			end
			S_EV_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_EV_EV;
			end
			S_EV_EV: begin
				// strict compare keeps the lowest index on a tie
				if (i_q == '0) cmd.ev_init = 1'b1;
				else cmd.ev_step = 1'b1;
				if ((IW+1)'(i_q) == LAST_IDX) begin
					cmd.ev_done = 1'b1;
					state_d = S_UPD;
				end else begin
					i_d = i_q + IW'(1);
					state_d = S_EV_RD;
				end
			end
			S_UPD: begin
				cmd.wr = 1'b1;
				state_d = S_DONE;
			end
			S_F1_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_F1_EV;
			end
			S_F1_EV: begin
				cmd.f_count = 1'b1;
				if (i_last) begin
					i_d = '0;
					state_d = S_F2I_RD;
				end else begin
					i_d = i_q + IW'(1);
					state_d = S_F1_RD;
				end
			end
			S_F2I_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_F2I_EV;
			end
			S_F2I_EV: begin
				cmd.f_i_latch = 1'b1;
				j_d = '0;
				state_d = S_F2J_CHK;
			end
			S_F2J_CHK: begin
				idx = j_q;
				if (j_q == i_q) begin
					if (j_last) state_d = S_F2_NEXT;
					else j_d = j_q + IW'(1);
				end else begin
					cmd.rd_en = 1'b1;
					state_d = S_F2J_EV;
				end
			end
			S_F2J_EV: begin
				idx = j_q;
				if (sts.link_ok) begin
					cmd.f_link = 1'b1;
					state_d = S_F2_NEXT;
				end else if (j_last) begin
					state_d = S_F2_NEXT;
				end else begin
					j_d = j_q + IW'(1);
					state_d = S_F2J_CHK;
				end
			end
			S_F2_NEXT: begin
				if (i_last) begin
					state_d = S_F_APP;
				end else begin
					i_d = i_q + IW'(1);
					state_d = S_F2I_RD;
				end
			end
			S_F_APP: begin
				cmd.f_apparent = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/probe_sequence_tracker.sv
// ----------------------------------------------------------------------------
// probe_sequence_tracker
// Table of probe request source addresses with sequence and scan tracking,
// eviction of the oldest entry, and finalize aggregates.
//
//   channel   signals                         direction
//   in        in_valid/in_ready + 3 fields    into block
//   out       out_valid/out_ready + 7 fields  out of block
//   cfg       cfg_wr_en, cfg_index, cfg_data  into block, write only
//
// One transaction at a time; n = filled entries, D = TABLE_DEPTH.
// Observe searches up to the n filled entries, plus all D entries for the
// victim when the table is full; begin scan and unused modes pass straight on.
// Finalize walks the n entries, then pairs of entries; every step is one read
// of the entry memory followed by an evaluate step.
// Reset needs no clearing pass; a full output register stalls the final step.
// ----------------------------------------------------------------------------
`default_nettype none

module probe_sequence_tracker import psq_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [47:0] source_address,
	input  wire logic [15:0] sequence_number,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      total_probes,
	output logic [15:0]      dropped_entries,
	output logic [6:0]       distinct_addresses,
	output logic [6:0]       linked_count,
	output logic [6:0]       short_sequence_count,
	output logic [6:0]       long_sequence_count,
	output logic [6:0]       apparent_count
);

	localparam int IW = $clog2(TABLE_DEPTH);

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] idx;
	logic [IW:0]   fill;

	psq_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.fill      (fill),
		.cmd       (cmd),
		.idx       (idx)
	);

	psq_dp #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW)) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_wr_en            (cfg_wr_en),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.mode                 (mode),
		.source_address       (source_address),
		.sequence_number      (sequence_number),
		.cmd                  (cmd),
		.idx                  (idx),
		.sts                  (sts),
		.fill                 (fill),
		.total_probes         (total_probes),
		.dropped_entries      (dropped_entries),
		.distinct_addresses   (distinct_addresses),
		.linked_count         (linked_count),
		.short_sequence_count (short_sequence_count),
		.long_sequence_count  (long_sequence_count),
		.apparent_count       (apparent_count)
	);

endmodule

`default_nettype wire

### rtl/core/psq_checker.sv
// ----------------------------------------------------------------------------
// psq_checker
// Port-level checks of the probe sequence tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] total_probes,
	input wire logic [6:0]  distinct_addresses,
	input wire logic [6:0]  linked_count,
	input wire logic [6:0]  short_sequence_count,
	input wire logic [6:0]  long_sequence_count,
	input wire logic [6:0]  apparent_count
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_probes))
		else $error("result changed while stalled");

	// one transaction in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second transaction while busy");

	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 7'(short_sequence_count + long_sequence_count) == distinct_addresses)
		else $error("short plus long differs from distinct");

	a_apparent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 7'(apparent_count + linked_count) == distinct_addresses)
		else $error("apparent plus linked differs from distinct");

endmodule

bind probe_sequence_tracker psq_checker u_psq_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.in_valid             (in_valid),
	.in_ready             (in_ready),
	.out_valid            (out_valid),
	.out_ready            (out_ready),
	.total_probes         (total_probes),
	.distinct_addresses   (distinct_addresses),
	.linked_count         (linked_count),
	.short_sequence_count (short_sequence_count),
	.long_sequence_count  (long_sequence_count),
	.apparent_count       (apparent_count)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for probe_sequence_tracker. It predicts the counters
// after every accepted transaction from its own copy of the address table and
// compares every output transaction in order. The stimulus is a directed
// opening followed by random traffic from a few devices that hop addresses,
// with random noise and random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import psq_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  mode;
		logic [47:0] addr;
		logic [15:0] seq;
	} probe_t;

	typedef struct {
		logic [15:0] total;
		logic [15:0] dropped;
		logic [6:0]  distinct;
		logic [6:0]  linked;
		logic [6:0]  short_cnt;
		logic [6:0]  long_cnt;
		logic [6:0]  apparent;
	} counters_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [11:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [47:0] source_address = '0;
	logic [15:0] sequence_number = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] total_probes, dropped_entries;
	logic [6:0]  distinct_addresses, linked_count, short_sequence_count;
	logic [6:0]  long_sequence_count, apparent_count;

	probe_sequence_tracker dut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic        keep_detail = 1'b0;
	logic [11:0] window = DEFAULT_WINDOW;
	logic [47:0] t_addr[DEPTH];
	logic        t_used[DEPTH];
	logic [11:0] t_fseq[DEPTH], t_lseq[DEPTH], t_mseq[DEPTH];
	logic [15:0] t_fscan[DEPTH], t_lscan[DEPTH], t_hits[DEPTH];
	logic        t_linked[DEPTH];
	int          filled = 0;
	logic [15:0] scan_idx = '0;
	logic [15:0] c_total = '0, c_dropped = '0, c_distinct = '0, c_linked = '0;
	logic [15:0] c_short = '0, c_long = '0, c_apparent = '0;

	probe_t    pending_probes[$];
	counters_t expected_counters[$];
	int        errors = 0;
	int        send_idle_pct = 37, recv_idle_pct = 50;
	logic      hold_sender = 1'b0;
	logic      taken = 1'b0;

	// device model for random traffic
	logic [47:0] dev_addr[8];
	logic [11:0] dev_seq[8];

	function automatic logic [15:0] sat16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void observe_probe(input logic [47:0] a, input logic [15:0] s16);
		logic [11:0] s;
		int k;
		logic fresh;
		logic [15:0] oldest;
		s = s16[11:0];
		k = -1;
		fresh = 1'b0;
		c_total = sat16(c_total);
		if (!keep_detail)
			return;
		for (int i = 0; i < filled; i++) begin
			if (k < 0 && t_used[i] && t_addr[i] == a) begin
				k = i;
				fresh = (t_hits[i] == 0);
			end
		end
		if (k < 0 && filled < DEPTH) begin
			k = filled;
			filled++;
			fresh = 1'b1;
		end else if (k < 0) begin
			k = 0;
			oldest = t_lscan[0];
			for (int i = 1; i < DEPTH; i++) begin
				if (t_lscan[i] < oldest) begin
					oldest = t_lscan[i];
					k = i;
				end
			end
			c_dropped = sat16(c_dropped);
			fresh = 1'b1;
		end
		if (fresh) begin
			t_used[k] = 1'b1;
			t_addr[k] = a;
			t_fseq[k] = s;
			t_mseq[k] = s;
			t_fscan[k] = scan_idx;
			t_hits[k] = '0;
			t_linked[k] = 1'b0;
		end else if (s > t_mseq[k]) begin
			t_mseq[k] = s;
		end
		t_lseq[k] = s;
		t_lscan[k] = scan_idx;
		t_hits[k] = sat16(t_hits[k]);
	endfunction

	function automatic void finalize_table();
		logic [15:0] gap;
		logic [11:0] delta;
		c_distinct = '0;
		c_linked = '0;
		c_short = '0;
		c_long = '0;
		for (int i = 0; i < filled; i++) begin
			if (t_used[i]) begin
				c_distinct = sat16(c_distinct);
				if (t_mseq[i] > LONG_SEQ_LIMIT) c_long = sat16(c_long);
				else c_short = sat16(c_short);
			end
		end
		for (int i = 0; i < filled; i++) begin
			if (!t_used[i]) continue;
			for (int j = 0; j < filled; j++) begin
				if (i == j || !t_used[j] || t_linked[j]) continue;
				gap = (t_lscan[i] > t_fscan[j]) ? t_lscan[i] - t_fscan[j]
					: t_fscan[j] - t_lscan[i];
				if (gap > 1) continue;
				delta = t_fseq[j] - t_lseq[i];
				if (delta >= 1 && delta <= window) begin
					t_linked[j] = 1'b1;
					c_linked = sat16(c_linked);
					break;
				end
			end
		end
		c_apparent = (c_distinct > c_linked) ? c_distinct - c_linked : '0;
	endfunction

	function automatic counters_t apply_probe(input probe_t p);
		counters_t r;
		case (p.mode)
			MODE_OBSERVE: observe_probe(p.addr, p.seq);
			MODE_SCAN: begin
				scan_idx = scan_idx + 16'd1;
				for (int i = 0; i < DEPTH; i++) t_linked[i] = 1'b0;
			end
			MODE_FINAL: finalize_table();
			default: ;
		endcase
		r.total = c_total;
		r.dropped = c_dropped;
		r.distinct = c_distinct[6:0];
		r.linked = c_linked[6:0];
		r.short_cnt = c_short[6:0];
		r.long_cnt = c_long[6:0];
		r.apparent = c_apparent[6:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// driver: hold valid until the transaction is taken
	always @(negedge clk) begin
		if (in_valid && !taken) begin
			in_valid <= 1'b1;
		end else if (pending_probes.size() > 0 && !hold_sender && arst_n
				&& $urandom_range(99) >= send_idle_pct) begin
			probe_t p;
			p = pending_probes.pop_front();
			in_valid <= 1'b1;
			mode <= p.mode;
			source_address <= p.addr;
			sequence_number <= p.seq;
		end else begin
			in_valid <= 1'b0;
		end
		taken <= 1'b0;
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			probe_t p;
			p.mode = mode;
			p.addr = source_address;
			p.seq = sequence_number;
			expected_counters.push_back(apply_probe(p));
			taken <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_counters.size() == 0) begin
				$error("output transaction with no expectation pending");
				errors++;
			end else begin
				counters_t e;
				e = expected_counters.pop_front();
				check_field("total_probes", e.total, total_probes);
				check_field("dropped_entries", e.dropped, dropped_entries);
				check_field("distinct_addresses", e.distinct, distinct_addresses);
				check_field("linked_count", e.linked, linked_count);
				check_field("short_sequence_count", e.short_cnt, short_sequence_count);
				check_field("long_sequence_count", e.long_cnt, long_sequence_count);
				check_field("apparent_count", e.apparent, apparent_count);
			end
		end
	end

	function automatic logic [47:0] rand_addr();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic void add_probe(input logic [1:0] m, input logic [47:0] a,
			input logic [15:0] s);
		probe_t p;
		p.mode = m;
		p.addr = a;
		p.seq = s;
		pending_probes.push_back(p);
	endfunction

	// devices that hop addresses while their sequence runs on
	function automatic void add_random_probe();
		int r, d;
		r = $urandom_range(99);
		d = $urandom_range(7);
		if (r < 4) add_probe(MODE_FINAL, rand_addr(), 16'($urandom));
		else if (r < 11) add_probe(MODE_SCAN, rand_addr(), 16'($urandom));
		else if (r < 13) add_probe(MODE_UNUSED, rand_addr(), 16'($urandom));
		else if (r < 20) add_probe(MODE_OBSERVE, rand_addr(), 16'($urandom));
		else begin
			if ($urandom_range(9) == 0) dev_addr[d] = rand_addr();
			dev_seq[d] = dev_seq[d] + 12'($urandom_range(1, 40));
			add_probe(MODE_OBSERVE, dev_addr[d], {4'($urandom), dev_seq[d]});
		end
	endfunction

	task automatic drain();
		wait (pending_probes.size() == 0 && !in_valid && expected_counters.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [11:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_RETAIN) keep_detail = val[0];
		else window = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(input int n);
		repeat (n) add_random_probe();
		drain();
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			t_addr[i] = '0; t_used[i] = 1'b0; t_fseq[i] = '0; t_lseq[i] = '0;
			t_mseq[i] = '0; t_fscan[i] = '0; t_lscan[i] = '0; t_hits[i] = '0;
			t_linked[i] = 1'b0;
		end
		for (int d = 0; d < 8; d++) begin
			dev_addr[d] = rand_addr();
			dev_seq[d] = 12'($urandom);
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// counting only
		add_probe(MODE_OBSERVE, 48'h0, 16'h0);
		add_probe(MODE_OBSERVE, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		add_probe(MODE_SCAN, '0, '0);
		add_probe(MODE_FINAL, '0, '0);
		add_probe(MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		drain();

		// detail on, window of one
		write_reg(REG_RETAIN, 12'd1);
		write_reg(REG_WINDOW, 12'd1);
		add_probe(MODE_OBSERVE, 48'h0000_0000_00A1, 16'd10);
		add_probe(MODE_OBSERVE, 48'h0000_0000_00A1, 16'd5);
		add_probe(MODE_OBSERVE, 48'h0000_0000_00B2, 16'h0FFF);
		add_probe(MODE_OBSERVE, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		add_probe(MODE_SCAN, '0, '0);
		add_probe(MODE_OBSERVE, 48'h0000_0000_00C3, 16'd11);
		add_probe(MODE_OBSERVE, 48'h0000_0000_00D4, 16'd6);
		add_probe(MODE_OBSERVE, 48'h0, 16'h0800);
		add_probe(MODE_FINAL, '0, '0);
		add_probe(MODE_FINAL, '0, '0);
		add_probe(MODE_SCAN, '0, '0);
		add_probe(MODE_FINAL, '0, '0);
		add_probe(MODE_UNUSED, 48'h5555_AAAA_5555, 16'hAAAA);
		drain();

		send_idle_pct = 37;
		recv_idle_pct = 50;
		write_reg(REG_WINDOW, 12'($urandom_range(2, 4094)));
		random_phase(500);

		send_idle_pct = 50;
		recv_idle_pct = 37;
		write_reg(REG_WINDOW, 12'd4095);
		repeat (200) add_random_probe();
		// let part of the burst through, then hold until every result is back
		wait (pending_probes.size() <= 100);
		hold_sender = 1'b1;
		wait (expected_counters.size() == 0 && !in_valid);
		repeat (5) @(posedge clk);
		hold_sender = 1'b0;
		repeat (200) add_random_probe();
		drain();
		write_reg(REG_WINDOW, 12'd0);
		random_phase(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_RETAIN, 12'd0);
		write_reg(REG_WINDOW, DEFAULT_WINDOW);
		random_phase(100);
		write_reg(REG_RETAIN, 12'd1);
		write_reg(REG_WINDOW, 12'($urandom_range(1, 4095)));
		random_phase(250);

		repeat (50) @(posedge clk);
		if (errors == 0 && expected_counters.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
